// File: hw/rtl/dpa_pkg.sv
// Shared constants for the distance approach PI controller.
// Register indexes, field widths and reset values; no dependencies.
package dpa_pkg;

	localparam int DIST_W  = 14;
	localparam int GAIN_W  = 16;
	localparam int SPEED_W = 7;
	localparam int OUT_W   = 8;
	localparam int ERR_W   = DIST_W + 1;
	localparam int PROD_W  = 32;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 16;

	typedef enum logic [CFG_AW-1:0] {
		REG_TARGET_DISTANCE = 3'd0,
		REG_TOLERANCE       = 3'd1,
		REG_PROP_GAIN       = 3'd2,
		REG_INTEG_GAIN      = 3'd3,
		REG_INTEGRAL_LIMIT  = 3'd4,
		REG_MIN_SPEED       = 3'd5,
		REG_MAX_SPEED       = 3'd6
	} cfg_reg_t;

	localparam logic [DIST_W-1:0]  RST_TARGET_DISTANCE = 14'd0;
	localparam logic [DIST_W-1:0]  RST_TOLERANCE       = 14'd8;
	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN       = 16'd4096;
	localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN      = 16'd102;
	localparam logic [DIST_W-1:0]  RST_INTEGRAL_LIMIT  = 14'd160;
	localparam logic [SPEED_W-1:0] RST_MIN_SPEED       = 7'd15;
	localparam logic [SPEED_W-1:0] RST_MAX_SPEED       = 7'd40;

endpackage

// File: hw/rtl/distance_pi_approach.sv
// Top level of the distance approach PI controller: stream in, stream out.
// Depends on dpa_pkg for widths, register indexes and reset values.
//
// One distance beat in gives one speed beat out, and a new beat is taken every
// cycle unless the output stalls. Stage 1 holds the distance and updates the
// clamped integral; stage 2 forms the two gain products; stage 3 sums, scales,
// clamps the magnitude and applies the sign into the output register. Each
// stage holds only while its successor is full and stalled. Within tolerance
// the result is zero speed with arrived set, and the integral is cleared.
module distance_pi_approach
	import dpa_pkg::*;
#(
	parameter int DIST_FRAC_BITS = 4,
	parameter int GAIN_FRAC_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_AW-1:0]    cfg_addr,
	input  logic [CFG_DW-1:0]    cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [13:0] distance
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [7:0] left_speed, [15:8] right_speed
	output logic                 m_tuser    // [0] arrived
);

	localparam int SHIFT = DIST_FRAC_BITS + GAIN_FRAC_BITS;

	logic [DIST_W-1:0]  target_q, tolerance_q, limit_q;
	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q;
	logic [SPEED_W-1:0] min_speed_q, max_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= RST_TARGET_DISTANCE;
			tolerance_q  <= RST_TOLERANCE;
			prop_gain_q  <= RST_PROP_GAIN;
			integ_gain_q <= RST_INTEG_GAIN;
			limit_q      <= RST_INTEGRAL_LIMIT;
			min_speed_q  <= RST_MIN_SPEED;
			max_speed_q  <= RST_MAX_SPEED;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TARGET_DISTANCE: target_q     <= cfg_wdata[DIST_W-1:0];
				REG_TOLERANCE:       tolerance_q  <= cfg_wdata[DIST_W-1:0];
				REG_PROP_GAIN:       prop_gain_q  <= cfg_wdata[GAIN_W-1:0];
				REG_INTEG_GAIN:      integ_gain_q <= cfg_wdata[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT:  limit_q      <= cfg_wdata[DIST_W-1:0];
				REG_MIN_SPEED:       min_speed_q  <= cfg_wdata[SPEED_W-1:0];
				REG_MAX_SPEED:       max_speed_q  <= cfg_wdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !m_tvalid || m_tready;
	assign ready_s2 = !valid_s3 || ready_s3;
	assign ready_s1 = !valid_s2 || ready_s2;
	assign s_tready = !valid_s1 || ready_s1;

	// stage 1: input register, error, arrival test, integral update
	logic [DIST_W-1:0]       distance_s1;
	logic signed [ERR_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0] err;
	logic [ERR_W-1:0]        aerr;
	logic                    arrived;
	logic signed [ERR_W:0]   acc_raw;
	logic signed [ERR_W:0]   lim_s;
	logic signed [ERR_W-1:0] acc;

	always_comb begin
		err     = $signed({1'b0, distance_s1}) - $signed({1'b0, target_q});
		aerr    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
		arrived = aerr <= {1'b0, tolerance_q};
		acc_raw = $signed({error_sum_q[ERR_W-1], error_sum_q})
			+ $signed({err[ERR_W-1], err});
		lim_s   = $signed({2'b00, limit_q});
		if (acc_raw < -lim_s) acc = ERR_W'(-lim_s);
		else if (acc_raw > lim_s) acc = ERR_W'(lim_s);
		else acc = ERR_W'(acc_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			error_sum_q <= '0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (valid_s1 && ready_s1) error_sum_q <= arrived ? '0 : acc;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) distance_s1 <= s_tdata[DIST_W-1:0];
	end

	// stage 2: gain products
	logic signed [ERR_W-1:0] err_s2, acc_s2;
	logic                    arrived_s2, pos_s2;
	logic signed [PROD_W-1:0] prod_p, prod_i;

	assign prod_p = PROD_W'($signed({1'b0, prop_gain_q})) * PROD_W'(err_s2);
	assign prod_i = PROD_W'($signed({1'b0, integ_gain_q})) * PROD_W'(acc_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (ready_s1) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			err_s2     <= err;
			acc_s2     <= acc;
			arrived_s2 <= arrived;
			pos_s2     <= !err[ERR_W-1] && (err != '0);
		end
	end

	// stage 3: sum, scale, clamp, sign
	logic signed [PROD_W-1:0] prod_p_s3, prod_i_s3;
	logic                     arrived_s3, pos_s3;
	logic signed [PROD_W-1:0] sum;
	logic [PROD_W-1:0]        mag;
	logic [SPEED_W-1:0]       spd;
	logic [OUT_W-1:0]         code;

	always_comb begin
		sum = prod_p_s3 + prod_i_s3;
		mag = (sum[PROD_W-1] ? PROD_W'(-sum) : PROD_W'(sum)) >> SHIFT;
		if (mag < PROD_W'(min_speed_q)) spd = min_speed_q;
		else if (mag > PROD_W'(max_speed_q)) spd = max_speed_q;
		else spd = mag[SPEED_W-1:0];
		if (arrived_s3) code = '0;
		else if (pos_s3) code = {1'b0, spd};
		else code = OUT_W'(-{1'b0, spd});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (ready_s2) valid_s3 <= valid_s2;
			if (ready_s3) m_tvalid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s2) begin
			prod_p_s3  <= prod_p;
			prod_i_s3  <= prod_i;
			arrived_s3 <= arrived_s2;
			pos_s3     <= pos_s2;
		end
		if (valid_s3 && ready_s3) begin
			m_tdata <= {code, code};
			m_tuser <= arrived_s3;
		end
	end

	a_arrived_stops: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("arrived beat with nonzero speed");

	a_wheels_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] == m_tdata[15:8])
		else $error("left and right speeds differ");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !ready_s3 |=> valid_s3)
		else $error("stage 3 beat lost under stall");

	a_clear_on_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s1 && arrived |=> error_sum_q == '0)
		else $error("integral not cleared on arrival");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for distance_pi_approach: random and directed distance beats
// against a cycle-free PI controller predictor. Depends on dpa_pkg and the RTL top.
module tb;
	import dpa_pkg::*;

	localparam int SCALE_SHIFT    = 4 + 10;
	localparam int DIST_MAX       = 16383;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 175;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic       arrived;
		logic [7:0] right;
		logic [7:0] left;
	} speed_cmd_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_AW-1:0]   cfg_addr = '0;
	logic [CFG_DW-1:0]   cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [15:0]         s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [15:0]         m_tdata;
	logic                m_tuser;

	logic [DIST_W-1:0]   tgt_cfg = RST_TARGET_DISTANCE;
	logic [DIST_W-1:0]   tol_cfg = RST_TOLERANCE;
	logic [GAIN_W-1:0]   kp_cfg  = RST_PROP_GAIN;
	logic [GAIN_W-1:0]   ki_cfg  = RST_INTEG_GAIN;
	logic [DIST_W-1:0]   lim_cfg = RST_INTEGRAL_LIMIT;
	logic [SPEED_W-1:0]  min_cfg = RST_MIN_SPEED;
	logic [SPEED_W-1:0]  max_cfg = RST_MAX_SPEED;
	int                  integ_model = 0;

	logic [DIST_W-1:0]   dist_backlog[$];
	speed_cmd_t          cmd_expected[$];
	int                  n_queued = 0;
	int                  n_out = 0;
	int                  n_in = 0;
	int                  n_fail = 0;
	int                  stall_cycles = 0;
	int                  tx_idle_pct = 10;
	int                  rx_idle_pct = 46;
	logic                rx_hold = 1'b0;
	logic                hold_go = 1'b0;

	distance_pi_approach dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [13:0] distance
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] left_speed, [15:8] right_speed
		.m_tuser   (m_tuser)    // [0] arrived
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// distance driver
	always @(posedge clk) begin
		if (!s_tvalid || s_tready) begin
			if (arst_n && dist_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {2'b00, dist_backlog.pop_front()};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// long receiver hold-off to fill the pipeline
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// speed prediction and result check
	always @(posedge clk) begin
		logic signed [15:0] err;
		logic [15:0]        aerr;
		int                 acc;
		int                 lim;
		longint             gp;
		longint             gi;
		longint             el;
		longint             sum;
		longint             mag;
		logic [7:0]         spd;
		speed_cmd_t         cmd;
		speed_cmd_t         want;
		speed_cmd_t         got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				err  = $signed({2'b00, s_tdata[DIST_W-1:0]}) - $signed({2'b00, tgt_cfg});
				aerr = (err < 0) ? -err : err;
				if (aerr <= {2'b00, tol_cfg}) begin
					integ_model = 0;
					cmd.left    = 8'd0;
					cmd.right   = 8'd0;
					cmd.arrived = 1'b1;
				end else begin
					lim = lim_cfg;
					acc = integ_model + err;
					if (acc < -lim)
						acc = -lim;
					if (acc > lim)
						acc = lim;
					integ_model = acc;
					gp  = kp_cfg;
					gi  = ki_cfg;
					el  = err;
					sum = gp * el + gi * acc;
					mag = (sum < 0) ? -sum : sum;
					mag = mag >> SCALE_SHIFT;
					if (mag < min_cfg)
						spd = {1'b0, min_cfg};
					else if (mag > max_cfg)
						spd = {1'b0, max_cfg};
					else
						spd = mag[7:0];
					cmd.left    = (err > 0) ? spd : -spd;
					cmd.right   = cmd.left;
					cmd.arrived = 1'b0;
				end
				cmd_expected.push_back(cmd);
				n_in <= n_in + 1;
			end
			if (m_tvalid && m_tready) begin
				got.left    = m_tdata[7:0];
				got.right   = m_tdata[15:8];
				got.arrived = m_tuser;
				n_out <= n_out + 1;
				if (cmd_expected.size() == 0) begin
					if (n_fail < 10)
						$display("unexpected speed beat: L=%0d R=%0d arrived=%0b",
							$signed(got.left), $signed(got.right), got.arrived);
					n_fail <= n_fail + 1;
				end else begin
					want = cmd_expected.pop_front();
					if (got.left !== want.left || got.right !== want.right ||
							got.arrived !== want.arrived) begin
						if (n_fail < 10)
							$display({"speed mismatch at beat %0d: ",
								"exp L=%0d R=%0d A=%0b, got L=%0d R=%0d A=%0b"},
								n_out, $signed(want.left), $signed(want.right),
								want.arrived, $signed(got.left), $signed(got.right),
								got.arrived);
						n_fail <= n_fail + 1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val[CFG_DW-1:0];
		case (idx)
			REG_TARGET_DISTANCE: tgt_cfg = val[DIST_W-1:0];
			REG_TOLERANCE:       tol_cfg = val[DIST_W-1:0];
			REG_PROP_GAIN:       kp_cfg  = val[GAIN_W-1:0];
			REG_INTEG_GAIN:      ki_cfg  = val[GAIN_W-1:0];
			REG_INTEGRAL_LIMIT:  lim_cfg = val[DIST_W-1:0];
			REG_MIN_SPEED:       min_cfg = val[SPEED_W-1:0];
			REG_MAX_SPEED:       max_cfg = val[SPEED_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (n_out != n_queued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int unsigned tgt, input int unsigned tol,
			input int unsigned kp, input int unsigned ki,
			input int unsigned lim, input int unsigned mn,
			input int unsigned mx);
		wait_drained();
		write_reg(REG_TARGET_DISTANCE, tgt);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_INTEGRAL_LIMIT, lim);
		write_reg(REG_MIN_SPEED, mn);
		write_reg(REG_MAX_SPEED, mx);
		write_reg(REG_UNUSED, $urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_distance(input int d);
		if (d < 0)
			d = 0;
		if (d > DIST_MAX)
			d = DIST_MAX;
		dist_backlog.push_back(d[DIST_W-1:0]);
		n_queued++;
	endtask

	initial begin
		int made;
		int tgt;
		int tol;
		int err;
		int steps;
		int r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_distance(0);
		queue_distance(8);
		queue_distance(9);
		queue_distance(DIST_MAX);
		queue_distance(100);

		configure(8000, 8, RST_PROP_GAIN, RST_INTEG_GAIN, RST_INTEGRAL_LIMIT,
			RST_MIN_SPEED, RST_MAX_SPEED);
		queue_distance(8000);
		queue_distance(8008);
		queue_distance(7992);
		queue_distance(8009);
		queue_distance(7991);
		queue_distance(0);
		queue_distance(DIST_MAX);
		queue_distance(8100);
		queue_distance(8050);
		queue_distance(8020);
		queue_distance(8010);
		queue_distance(7900);
		queue_distance(7950);
		queue_distance(7990);

		// min above max
		configure(8000, 0, 16'hFFFF, 16'hFFFF, DIST_MAX, 100, 20);
		queue_distance(8001);
		queue_distance(DIST_MAX);
		// both speed limits at the top speed
		configure(8000, 0, 16'hFFFF, 16'hFFFF, DIST_MAX, 127, 127);
		queue_distance(0);
		queue_distance(DIST_MAX);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1: configure($urandom_range(DIST_MAX), 0, $urandom_range(16'hFFFF), 16'hFFFF,
					0, $urandom_range(100), $urandom_range(100));
				2: configure($urandom_range(DIST_MAX), $urandom_range(64), 16'hFFFF, 16'hFFFF,
					DIST_MAX, 0, 127);
				3: configure($urandom_range(DIST_MAX), $urandom_range(64), 0, 0,
					$urandom_range(DIST_MAX), 100, 100);
				4: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				5: configure($urandom_range(DIST_MAX), DIST_MAX, $urandom_range(16'hFFFF),
					$urandom_range(16'hFFFF), $urandom_range(DIST_MAX), 0, 0);
				7: configure($urandom_range(DIST_MAX), RST_TOLERANCE, RST_PROP_GAIN,
					RST_INTEG_GAIN, RST_INTEGRAL_LIMIT, RST_MIN_SPEED, RST_MAX_SPEED);
				default: configure($urandom_range(DIST_MAX), $urandom_range(64),
					$urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
					$urandom_range(DIST_MAX), $urandom_range(100), $urandom_range(100));
			endcase
			if (ph < 3) begin
				tx_idle_pct = 10;
				rx_idle_pct = 46;
			end else if (ph < 6) begin
				tx_idle_pct = 46;
				rx_idle_pct = 10;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			tgt  = tgt_cfg;
			tol  = tol_cfg;
			made = 0;
			while (made < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 70) begin
					// approach run: shrink the error, then land inside the band
					err   = int'($urandom_range(DIST_MAX)) - tgt;
					steps = $urandom_range(15, 3);
					for (int k = 0; k < steps; k++) begin
						queue_distance(tgt + err);
						err = err * int'($urandom_range(90, 50)) / 100;
					end
					queue_distance(tgt + $urandom_range(2 * tol) - tol);
					made += steps + 1;
				end else if (r < 90) begin
					queue_distance($urandom_range(DIST_MAX));
					made++;
				end else begin
					queue_distance(tgt + $urandom_range(4 * tol + 4) - 2 * tol - 2);
					made++;
				end
			end
			if (ph == 1)
				hold_go = 1'b1;
		end

		wait_drained();
		if (n_fail == 0 && cmd_expected.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
